// File: sv/md2_pkg.sv
`timescale 1ns / 1ps
package md2_pkg;

  typedef logic [7:0] byte_t;

  localparam int BLK_LEN    = 16;
  localparam int STATE_LEN  = 48;
  localparam int NUM_ROUNDS = 18;

  // MD2 substitution table built from the digits of pi
  localparam byte_t SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage

// File: sv/md2_hash_engine_top.sv
`timescale 1ns / 1ps
// MD2 (RFC 1319) hash engine. Message bytes arrive one per input beat with
// in_tuser set; in_tlast ends the message, and a last beat with in_tuser clear
// carries no byte, so an empty message is allowed. A byte that does not
// complete a 16-byte block leaves the engine ready for the next beat. A byte
// that completes a block holds off the next beat through the checksum update,
// a block load and the compression rounds; the checksum update and the
// compression each run one dependent S-box step per cycle. The end of a message
// adds up to 16 padding bytes, one or two further block passes and the
// checksum block pass (load and compression only), after which the 16 digest
// bytes leave on out_tdata, one per beat, with out_tlast on the last.
// The hash state, checksum and message flags then return to their reset values
// for the next message.
module md2_hash_engine_top
  import md2_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] msg_byte
  input  logic       in_tuser,   // [0] has_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] digest_byte
  output logic       out_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CSUM = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_r;
  logic [3:0] fill_r;
  logic [4:0] pad_r;
  logic [5:0] step_r;
  logic [4:0] rnd_r;
  logic [3:0] ocnt_r;
  logic       final_r;
  logic       pad_done_r;
  logic       ckblk_r;
  byte_t      link_r;
  byte_t      t_r;
  byte_t      buf_r [BLK_LEN];
  byte_t      ck_r  [BLK_LEN];
  byte_t      x_r   [STATE_LEN];

  byte_t      l_val;
  byte_t      t_nxt;
  byte_t      src   [BLK_LEN];
  logic       in_beat;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = x_r[0];
  assign out_tlast  = (ocnt_r == 4'd15);

  always_comb begin
    l_val = SBOX[buf_r[0] ^ link_r] ^ ck_r[0];
    t_nxt = x_r[0] ^ SBOX[t_r];
    for (int j = 0; j < BLK_LEN; j++) begin
      src[j] = ckblk_r ? ck_r[j] : buf_r[j];
    end
  end

  // block buffer: shift in bytes and pad at the tail, rotate during the checksum pass
  always_ff @(posedge clk) begin
    if (in_beat && in_tuser) begin
      for (int j = 0; j < BLK_LEN - 1; j++) buf_r[j] <= buf_r[j+1];
      buf_r[BLK_LEN-1] <= in_tdata;
    end else if (state_r == ST_CSUM) begin
      for (int j = 0; j < BLK_LEN - 1; j++) buf_r[j] <= buf_r[j+1];
      buf_r[BLK_LEN-1] <= buf_r[0];
    end else if (state_r == ST_PAD) begin
      for (int j = 0; j < BLK_LEN - 1; j++) buf_r[j] <= buf_r[j+1];
      buf_r[BLK_LEN-1] <= {3'b000, pad_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      pad_r      <= '0;
      step_r     <= '0;
      rnd_r      <= '0;
      ocnt_r     <= '0;
      final_r    <= 1'b0;
      pad_done_r <= 1'b0;
      ckblk_r    <= 1'b0;
      link_r     <= '0;
      t_r        <= '0;
      for (int j = 0; j < BLK_LEN; j++) ck_r[j] <= '0;
      for (int j = 0; j < STATE_LEN; j++) x_r[j] <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_tuser) begin
              fill_r <= fill_r + 4'd1;
              if (fill_r == 4'd15) begin
                state_r <= ST_CSUM;
                final_r <= in_tlast;
                step_r  <= '0;
              end else if (in_tlast) begin
                state_r <= ST_PAD;
                final_r <= 1'b1;
                pad_r   <= 5'd16 - {1'b0, fill_r + 4'd1};
              end
            end else if (in_tlast) begin
              state_r <= ST_PAD;
              final_r <= 1'b1;
              pad_r   <= 5'd16 - {1'b0, fill_r};
            end
          end
        end
        ST_PAD: begin
          fill_r <= fill_r + 4'd1;
          if (fill_r == 4'd15) begin
            pad_done_r <= 1'b1;
            state_r    <= ST_CSUM;
            step_r     <= '0;
          end
        end
        ST_CSUM: begin
          for (int j = 0; j < BLK_LEN - 1; j++) ck_r[j] <= ck_r[j+1];
          ck_r[BLK_LEN-1] <= l_val;
          link_r <= l_val;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd15) state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int j = 0; j < BLK_LEN; j++) begin
            x_r[BLK_LEN + j]   <= src[j];
            x_r[2*BLK_LEN + j] <= src[j] ^ x_r[j];
          end
          t_r     <= '0;
          rnd_r   <= '0;
          step_r  <= '0;
          state_r <= ST_RND;
        end
        ST_RND: begin
          // one S-box step: rotate the state so the next byte sits at the head
          for (int j = 0; j < STATE_LEN - 1; j++) x_r[j] <= x_r[j+1];
          x_r[STATE_LEN-1] <= t_nxt;
          if (step_r == 6'(STATE_LEN - 1)) begin
            step_r <= '0;
            t_r    <= t_nxt + {3'b000, rnd_r};
            rnd_r  <= rnd_r + 5'd1;
            if (rnd_r == 5'(NUM_ROUNDS - 1)) begin
              if (ckblk_r) begin
                state_r <= ST_OUT;
                ocnt_r  <= '0;
              end else if (!final_r) begin
                state_r <= ST_IDLE;
              end else if (!pad_done_r) begin
                // final byte filled the block: a whole pad block follows
                state_r <= ST_PAD;
                pad_r   <= 5'd16;
              end else begin
                ckblk_r <= 1'b1;
                state_r <= ST_LOAD;
              end
            end
          end else begin
            step_r <= step_r + 6'd1;
            t_r    <= t_nxt;
          end
        end
        ST_OUT: begin
          if (out_tready) begin
            for (int j = 0; j < STATE_LEN - 1; j++) x_r[j] <= x_r[j+1];
            x_r[STATE_LEN-1] <= '0;
            ocnt_r <= ocnt_r + 4'd1;
            if (ocnt_r == 4'd15) begin
              // drop all hash state for the next message
              state_r    <= ST_IDLE;
              fill_r     <= '0;
              final_r    <= 1'b0;
              pad_done_r <= 1'b0;
              ckblk_r    <= 1'b0;
              link_r     <= '0;
              t_r        <= '0;
              for (int j = 0; j < BLK_LEN; j++) ck_r[j] <= '0;
              for (int j = 0; j < STATE_LEN; j++) x_r[j] <= '0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while digest pending");

  a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD) |-> (pad_r != 5'd0) && (pad_r <= 5'd16))
    else $error("pad length out of range");

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND) |-> (rnd_r < 5'(NUM_ROUNDS)) && (step_r < 6'(STATE_LEN)))
    else $error("round counters out of range");

  a_idle_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready && (fill_r == 4'd0))
    else $error("engine not cleared after digest");

  a_out_only_ckblk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ckblk_r && pad_done_r && final_r)
    else $error("digest emitted before checksum block");

endmodule

// File: sim/md2_hash_engine_top_test.sv
`timescale 1ns / 1ps
module md2_hash_engine_top_test;
  import md2_pkg::*;

  typedef struct {
    byte_t val;
    logic  is_last;
  } digest_beat_t;

  typedef struct {
    byte_t        b;
    logic         has;
    logic         fin;
    logic [127:0] dig;
    bit           typed;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] msg_byte
  logic       in_tuser = 1'b0;    // [0] has_byte
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b1;
  logic [7:0] out_tdata;          // [7:0] digest_byte
  logic       out_tlast;

  md2_hash_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Digest predictor state
  byte_t       hash_st   [STATE_LEN];
  byte_t       sum_bytes [BLK_LEN];
  byte_t       sum_link;
  byte_t       blk_bytes [BLK_LEN];
  int unsigned blk_fill;

  digest_beat_t digest_q [$];
  stim_row_t    stim_rows [$];

  bit quiet = 1'b0;
  int errors = 0;
  int messages_done = 0;
  int digest_beats = 0;
  int ignored_beats = 0;
  int rand_items = 0;
  int stall_left = 0;
  int calm_left = 0;
  int pick_rdy;

  function automatic void clear_state();
    for (int k = 0; k < STATE_LEN; k++) hash_st[k] = '0;
    for (int j = 0; j < BLK_LEN; j++) begin
      sum_bytes[j] = '0;
      blk_bytes[j] = '0;
    end
    sum_link = '0;
    blk_fill = 0;
  endfunction

  function automatic void md2_compress(input logic [127:0] blk);
    byte_t t;
    t = '0;
    for (int j = 0; j < BLK_LEN; j++) begin
      hash_st[BLK_LEN + j]     = blk[8*j +: 8];
      hash_st[2 * BLK_LEN + j] = blk[8*j +: 8] ^ hash_st[j];
    end
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      for (int k = 0; k < STATE_LEN; k++) begin
        t = hash_st[k] ^ SBOX[t];
        hash_st[k] = t;
      end
      t = t + 8'(r);
    end
  endfunction

  // Update the checksum from the buffered block, then compress the block
  function automatic void fold_block();
    logic [127:0] blk;
    byte_t        l;
    for (int j = 0; j < BLK_LEN; j++) begin
      l = SBOX[blk_bytes[j] ^ sum_link] ^ sum_bytes[j];
      sum_bytes[j] = l;
      sum_link = l;
      blk[8*j +: 8] = blk_bytes[j];
    end
    md2_compress(blk);
  endfunction

  // Returns 1 with the digest (byte 0 in the top bits) when the item ends a message
  function automatic bit absorb_item(input byte_t b, input logic has, input logic fin,
                                     output logic [127:0] dig);
    logic [127:0] sum_packed;
    byte_t        pad;
    dig = '0;
    if (has) begin
      blk_bytes[blk_fill] = b;
      blk_fill++;
      if (blk_fill == BLK_LEN) begin
        fold_block();
        blk_fill = 0;
      end
    end
    if (!fin) return 1'b0;
    pad = 8'(BLK_LEN - blk_fill);
    for (int j = blk_fill; j < BLK_LEN; j++) blk_bytes[j] = pad;
    fold_block();
    for (int j = 0; j < BLK_LEN; j++) sum_packed[8*j +: 8] = sum_bytes[j];
    md2_compress(sum_packed);
    for (int k = 0; k < BLK_LEN; k++) dig[127 - 8*k -: 8] = hash_st[k];
    clear_state();
    return 1'b1;
  endfunction

  task automatic add_row(input byte_t b, input logic has, input logic fin,
                         input logic [127:0] dig, input bit typed);
    stim_row_t row;
    row.b = b;
    row.has = has;
    row.fin = fin;
    row.dig = dig;
    row.typed = typed;
    stim_rows.push_back(row);
  endtask

  task automatic send_item(input byte_t b, input logic has, input logic fin,
                           input logic [127:0] typed_dig, input bit use_typed);
    logic [127:0] dig;
    digest_beat_t beat;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!has && !fin) ignored_beats++;
    if (absorb_item(b, has, fin, dig)) begin
      if (use_typed) dig = typed_dig;
      for (int k = 0; k < BLK_LEN; k++) begin
        beat.val = dig[127 - 8*k -: 8];
        beat.is_last = (k == BLK_LEN - 1);
        digest_q.push_back(beat);
      end
      messages_done++;
    end
  endtask

  task automatic check_digest_beat(input byte_t got_b, input logic got_l);
    digest_beat_t want;
    if (digest_q.size() == 0) begin
      errors++;
      $display("%0t: digest beat with nothing expected: byte %h last %b",
               $time, got_b, got_l);
      return;
    end
    want = digest_q.pop_front();
    digest_beats++;
    if (got_b !== want.val) begin
      errors++;
      $display("%0t: digest_byte expected %h, got %h", $time, want.val, got_b);
    end
    if (got_l !== want.is_last) begin
      errors++;
      $display("%0t: digest_last expected %b, got %b", $time, want.is_last, got_l);
    end
  endtask

  // Check digest beats and stall the result side in short bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_digest_beat(out_tdata, out_tlast);
    if (stall_left > 0) begin
      stall_left--;
    end else if (calm_left > 0) begin
      calm_left--;
    end else if (!quiet) begin
      pick_rdy = $urandom_range(0, 15);
      if (pick_rdy < 4) stall_left = $urandom_range(1, 5);
      else if (pick_rdy == 4) calm_left = $urandom_range(20, 120);
    end
    out_tready <= quiet || (stall_left == 0);
  end

  initial begin
    int msg_idx;
    int body_len;
    int pick;
    msg_idx = 0;
    clear_state();

    // Empty message, "abc" with an ignored beat inside, single-byte extremes,
    // and a message whose final byte completes the block
    add_row(8'h00, 1'b0, 1'b1, 128'h8350e5a3e24c153df2275c9f80692773, 1'b1);
    add_row(8'h61, 1'b1, 1'b0, '0, 1'b0);
    add_row(8'h5a, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'h62, 1'b1, 1'b0, '0, 1'b0);
    add_row(8'h63, 1'b1, 1'b1, 128'hda853b0d3f88d99b30283a69e6ded6bb, 1'b1);
    add_row(8'hff, 1'b1, 1'b1, '0, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, '0, 1'b0);
    for (int i = 0; i < BLK_LEN; i++)
      add_row(8'(i * 17), 1'b1, i == BLK_LEN - 1, '0, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i])
      send_item(stim_rows[i].b, stim_rows[i].has, stim_rows[i].fin,
                stim_rows[i].dig, stim_rows[i].typed);

    while (rand_items < 350) begin
      quiet = (rand_items >= 300);
      // Hold off now and then until every digest is out
      if (!quiet && (msg_idx == 2 || $urandom_range(0, 5) == 0)) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) body_len = $urandom_range(0, 20);
      else if (pick < 9) body_len = $urandom_range(15, 48);
      else body_len = $urandom_range(0, 2);
      for (int i = 0; i < body_len; i++) begin
        quiet = (rand_items >= 300);
        if ($urandom_range(0, 15) == 0)
          send_item(8'($urandom), 1'b0, 1'b0, '0, 1'b0);
        send_item(8'($urandom), 1'b1, 1'b0, '0, 1'b0);
        rand_items++;
      end
      quiet = (rand_items >= 300);
      send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1, '0, 1'b0);
      rand_items++;
      msg_idx++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Hashed %0d messages (%0d random items, %0d ignored beats) under stalls,",
             messages_done, rand_items, ignored_beats);
    $display("checked %0d digest beats including empty and block-filling messages",
             digest_beats);
    if (errors == 0) begin
      $display("md2_hash_engine_top_test: clean");
    end else begin
      $display("md2_hash_engine_top_test: errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d digest beats outstanding", digest_q.size());
    $display("md2_hash_engine_top_test: errors");
    $finish;
  end

endmodule
